// File: design/cip_pkg.sv
package cip_pkg;

   localparam int GainW  = 24;
   localparam int LimitW = 31;
   localparam int DataW  = 32;
   localparam int ErrW   = 33;
   localparam int D1W    = 34;
   localparam int D2W    = 35;
   localparam int SumW   = 62;
   localparam int FracW  = 16;
   localparam int OutW   = 48;
   localparam int AddrW  = 4;
   localparam int CntW   = 5;

   typedef enum logic [AddrW-1:0] {
      REG_POS_GAIN_P = 4'd0,
      REG_POS_GAIN_I = 4'd1,
      REG_POS_GAIN_D = 4'd2,
      REG_POS_LIMIT  = 4'd3,
      REG_SPD_GAIN_P = 4'd4,
      REG_SPD_GAIN_I = 4'd5,
      REG_SPD_GAIN_D = 4'd6,
      REG_SPD_LIMIT  = 4'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      TERM_P = 2'd0,
      TERM_I = 2'd1,
      TERM_D = 2'd2
   } term_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
   } mac_ctrl_type;

endpackage

// File: design/cascaded_incremental_pid.sv
// Position mode runs both loops, position first; speed mode runs the speed loop only.
// Requests are taken only in idle, after the prior result is registered; each loop runs
// P, I and D through one bit-serial shift-add multiplier (one gain bit per cycle).
// Reset: synchronous, active high; clears gains, limits, errors and accumulators.
module cascaded_incremental_pid (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic signed [cip_pkg::DataW-1:0]  req_target,
   input  logic signed [cip_pkg::DataW-1:0]  req_angle_meas,
   input  logic signed [cip_pkg::DataW-1:0]  req_speed_meas,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [cip_pkg::DataW-1:0]  rsp_drive_out,
   output logic signed [cip_pkg::DataW-1:0]  rsp_speed_setpoint,
   input  logic                              csr_we,
   input  logic [cip_pkg::AddrW-1:0]         csr_addr,
   input  logic [cip_pkg::LimitW-1:0]        csr_wdata
);
   import cip_pkg::*;

   logic [GainW-1:0]  pos_gp_ff, pos_gi_ff, pos_gd_ff, spd_gp_ff, spd_gi_ff, spd_gd_ff;
   logic [LimitW-1:0] pos_lim_ff, spd_lim_ff;

   logic signed [ErrW-1:0]  pos_e0_ff, pos_e1_ff, spd_e0_ff, spd_e1_ff;
   logic signed [DataW-1:0] pos_acc_ff, spd_acc_ff;

   state_type state_ff, state_in;
   logic      lp_ff, lp_in;
   term_type  term_ff, term_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   logic                    func_ff;
   logic signed [DataW-1:0] target_ff, angle_ff, speed_ff;

   logic signed [ErrW-1:0] e_ff;
   logic signed [D1W-1:0]  d1_ff;
   logic signed [D2W-1:0]  d2_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [DataW-1:0] drive_ff, setp_ff;

   mac_ctrl_type           mac_ctrl;
   logic [GainW-1:0]       mac_gain;
   logic signed [SumW-1:0] mac_mcand, mac_sum;

   logic signed [DataW-1:0] ref_val, fdb_val, acc_cur;
   logic signed [ErrW-1:0]  e_cur, e0_cur, e1_cur;
   logic signed [D1W-1:0]   d1_cur;
   logic signed [D2W-1:0]   d2_cur;
   logic [GainW-1:0]        gp_cur, gi_cur, gd_cur;
   logic [LimitW-1:0]       lim_cur;
   logic signed [OutW-1:0]  out_raw, lim_pos, lim_neg, out_clamp;
   logic                    accept;

   cip_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .gain  (mac_gain),
      .mcand (mac_mcand),
      .sum   (mac_sum)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      gp_cur  = lp_ff ? spd_gp_ff  : pos_gp_ff;
      gi_cur  = lp_ff ? spd_gi_ff  : pos_gi_ff;
      gd_cur  = lp_ff ? spd_gd_ff  : pos_gd_ff;
      lim_cur = lp_ff ? spd_lim_ff : pos_lim_ff;
      e0_cur  = lp_ff ? spd_e0_ff  : pos_e0_ff;
      e1_cur  = lp_ff ? spd_e1_ff  : pos_e1_ff;
      acc_cur = lp_ff ? spd_acc_ff : pos_acc_ff;
      ref_val = (lp_ff && !func_ff) ? pos_acc_ff : target_ff;
      fdb_val = lp_ff ? speed_ff : angle_ff;
      e_cur   = ErrW'(ref_val) - ErrW'(fdb_val);
      d1_cur  = D1W'(e_cur) - D1W'(e1_cur);
      d2_cur  = D2W'(e_cur) - (D2W'(e1_cur) <<< 1) + D2W'(e0_cur);
   end

   always_comb begin
      case (term_ff)
         TERM_P: begin
            mac_gain  = gp_cur;
            mac_mcand = SumW'(d1_ff);
         end
         TERM_I: begin
            mac_gain  = gi_cur;
            mac_mcand = SumW'(e_ff);
         end
         TERM_D: begin
            mac_gain  = gd_cur;
            mac_mcand = SumW'(d2_ff);
         end
         default: begin
            mac_gain  = '0;
            mac_mcand = '0;
         end
      endcase
   end

   always_comb begin
      out_raw = OutW'(acc_cur) + OutW'($signed(mac_sum[SumW-1:FracW]));
      lim_pos = OutW'({1'b0, lim_cur});
      lim_neg = -lim_pos;
      if (out_raw > lim_pos) begin
         out_clamp = lim_pos;
      end else if (out_raw < lim_neg) begin
         out_clamp = lim_neg;
      end else begin
         out_clamp = out_raw;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lp_in        = lp_ff;
      term_in      = term_ff;
      cnt_in       = cnt_ff;
      mac_ctrl     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lp_in    = req_func;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            term_in  = TERM_P;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            mac_ctrl.load  = 1'b1;
            mac_ctrl.clear = (term_ff == TERM_P);
            cnt_in         = '0;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            mac_ctrl.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(GainW - 1)) begin
               if (term_ff == TERM_D) begin
                  state_in = ST_ACC;
               end else begin
                  term_in  = term_type'(term_ff + 2'd1);
                  state_in = ST_LOAD;
               end
            end
         end
         ST_ACC: begin
            if (lp_ff) begin
               state_in = ST_DONE;
            end else begin
               lp_in    = 1'b1;
               state_in = ST_ERR;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lp_ff        <= 1'b0;
         term_ff      <= TERM_P;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lp_ff        <= lp_in;
         term_ff      <= term_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_gp_ff  <= '0;
         pos_gi_ff  <= '0;
         pos_gd_ff  <= '0;
         pos_lim_ff <= '0;
         spd_gp_ff  <= '0;
         spd_gi_ff  <= '0;
         spd_gd_ff  <= '0;
         spd_lim_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_POS_GAIN_P: pos_gp_ff  <= csr_wdata[GainW-1:0];
            REG_POS_GAIN_I: pos_gi_ff  <= csr_wdata[GainW-1:0];
            REG_POS_GAIN_D: pos_gd_ff  <= csr_wdata[GainW-1:0];
            REG_POS_LIMIT:  pos_lim_ff <= csr_wdata;
            REG_SPD_GAIN_P: spd_gp_ff  <= csr_wdata[GainW-1:0];
            REG_SPD_GAIN_I: spd_gi_ff  <= csr_wdata[GainW-1:0];
            REG_SPD_GAIN_D: spd_gd_ff  <= csr_wdata[GainW-1:0];
            REG_SPD_LIMIT:  spd_lim_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_e0_ff  <= '0;
         pos_e1_ff  <= '0;
         pos_acc_ff <= '0;
         spd_e0_ff  <= '0;
         spd_e1_ff  <= '0;
         spd_acc_ff <= '0;
      end else if (state_ff == ST_ACC) begin
         if (lp_ff) begin
            spd_e0_ff  <= spd_e1_ff;
            spd_e1_ff  <= e_ff;
            spd_acc_ff <= out_clamp[DataW-1:0];
         end else begin
            pos_e0_ff  <= pos_e1_ff;
            pos_e1_ff  <= e_ff;
            pos_acc_ff <= out_clamp[DataW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_func;
         target_ff <= req_target;
         angle_ff  <= req_angle_meas;
         speed_ff  <= req_speed_meas;
      end
      if (state_ff == ST_ERR) begin
         e_ff  <= e_cur;
         d1_ff <= d1_cur;
         d2_ff <= d2_cur;
      end
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
         drive_ff <= spd_acc_ff;
         setp_ff  <= pos_acc_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_out      = drive_ff;
   assign rsp_speed_setpoint = setp_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ERR))
      else $error("accepted beat did not start a loop");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside completion");

   a_spd_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |->
         ($signed(OutW'(spd_acc_ff)) <= $signed(OutW'({1'b0, spd_lim_ff})) &&
          $signed(OutW'(spd_acc_ff)) >= -$signed(OutW'({1'b0, spd_lim_ff}))))
      else $error("speed accumulator beyond limit");

endmodule

// File: design/cip_mac.sv
module cip_mac (
   input  logic                               clock,
   input  cip_pkg::mac_ctrl_type              ctrl,
   input  logic [cip_pkg::GainW-1:0]          gain,
   input  logic signed [cip_pkg::SumW-1:0]    mcand,
   output logic signed [cip_pkg::SumW-1:0]    sum
);
   import cip_pkg::*;

   logic signed [SumW-1:0] sum_ff, sum_in;
   logic signed [SumW-1:0] mcand_ff, mcand_in;
   logic [GainW-1:0]       gsh_ff, gsh_in;

   always_comb begin
      sum_in   = sum_ff;
      mcand_in = mcand_ff;
      gsh_in   = gsh_ff;
      if (ctrl.clear) begin
         sum_in = '0;
      end
      if (ctrl.load) begin
         mcand_in = mcand;
         gsh_in   = gain;
      end else if (ctrl.step) begin
         if (gsh_ff[0]) begin
            sum_in = sum_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         gsh_in   = gsh_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      mcand_ff <= mcand_in;
      gsh_ff   <= gsh_in;
   end

   assign sum = sum_ff;

endmodule
